/* rtl/fpb_pkg.sv */
// ----------------------------------------------------------------------------
// fpb_pkg
// Shared types and constants for the flash patch breakpoint unit.
// ----------------------------------------------------------------------------
package fpb_pkg;

	// Command codes on the input channel
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_FETCH = 2'd2;

	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned IDX_W    = 4;

	// Register window
	localparam logic [OFFSET_W-1:0] OFS_CONTROL   = 12'h000;
	localparam logic [OFFSET_W-1:0] OFS_COMP_BASE = 12'h008;

	// Control register fields
	localparam int unsigned CTRL_ENABLE_BIT  = 0;
	localparam int unsigned CTRL_KEY_BIT     = 1;
	localparam int unsigned CTRL_COUNT_SHIFT = 4;
	localparam int unsigned CTRL_REV_SHIFT   = 28;
	localparam logic [3:0]  CTRL_REVISION    = 4'd1;

	localparam int unsigned DEFAULT_NUM_COMPARATORS = 6;

	// Access request from the top level to the comparator bank
	typedef struct packed {
		logic                wr_en;
		logic [OFFSET_W-1:0] offset;
		logic [DATA_W-1:0]   wdata;
	} bank_req_t;

	// Read and match results from the comparator bank
	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic              hit;
		logic [IDX_W-1:0]  idx;
	} bank_rsp_t;

endpackage

/* rtl/fpb_comp_bank.sv */
// ----------------------------------------------------------------------------
// fpb_comp_bank
// Comparator word storage with register decode, read mux and priority match.
// ----------------------------------------------------------------------------
module fpb_comp_bank #(
	parameter int unsigned NUM_COMPARATORS = fpb_pkg::DEFAULT_NUM_COMPARATORS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fpb_pkg::bank_req_t             req,
	input  logic [fpb_pkg::DATA_W-1:0]     fetch_address,
	output fpb_pkg::bank_rsp_t             rsp
);
	import fpb_pkg::*;

	logic [DATA_W-1:0]          words_q [NUM_COMPARATORS];
	logic [NUM_COMPARATORS-1:0] sel;
	logic [NUM_COMPARATORS-1:0] match;

	// One-hot slot decode: word n sits at base + 4*n
	always_comb begin
		for (int i = 0; i < NUM_COMPARATORS; i++) begin
			sel[i] = (req.offset == (OFS_COMP_BASE + OFFSET_W'(4 * i)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COMPARATORS; i++) begin
				words_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_COMPARATORS; i++) begin
				if (req.wr_en && sel[i]) begin
					words_q[i] <= req.wdata;
				end
			end
		end
	end

	// Match on enabled comparators, address with bit 0 cleared
	always_comb begin
		for (int i = 0; i < NUM_COMPARATORS; i++) begin
			match[i] = words_q[i][0] && ({words_q[i][DATA_W-1:1], 1'b0} == fetch_address);
		end
	end

	always_comb begin
		rsp.rdata = '0;
		rsp.hit   = |match;
		rsp.idx   = '0;
		for (int i = 0; i < NUM_COMPARATORS; i++) begin
			if (sel[i]) begin
				rsp.rdata = rsp.rdata | words_q[i];
			end
		end
		// Walk downward so the lowest match wins
		for (int i = NUM_COMPARATORS - 1; i >= 0; i--) begin
			if (match[i]) begin
				rsp.idx = IDX_W'(i);
			end
		end
	end

endmodule

/* rtl/flash_patch_breakpoint_unit.sv */
// ----------------------------------------------------------------------------
// flash_patch_breakpoint_unit
// Register-window breakpoint unit: privileged register access plus fetch check.
// ----------------------------------------------------------------------------
// Path: input register, then result register; the decode, read mux and
//   comparator match sit between the two registers.
// Throughput: one word per cycle while out_ready stays high.
// Reset: arst_n clears the enable bit, all comparator words and both valid flags.
// ----------------------------------------------------------------------------
module flash_patch_breakpoint_unit #(
	parameter int unsigned NUM_COMPARATORS = fpb_pkg::DEFAULT_NUM_COMPARATORS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       command,
	input  logic [fpb_pkg::OFFSET_W-1:0]     offset,
	input  logic [fpb_pkg::DATA_W-1:0]       write_data,
	input  logic                             user_access,
	input  logic [fpb_pkg::DATA_W-1:0]       fetch_address,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fpb_pkg::DATA_W-1:0]       read_data,
	output logic                             bus_error,
	output logic                             breakpoint_hit,
	output logic [fpb_pkg::IDX_W-1:0]        hit_index
);
	import fpb_pkg::*;

	// Input stage
	logic                valid_s1;
	logic [1:0]          command_s1;
	logic [OFFSET_W-1:0] offset_s1;
	logic [DATA_W-1:0]   write_data_s1;
	logic                user_access_s1;
	logic [DATA_W-1:0]   fetch_address_s1;

	logic enable_q;
	logic advance_s1;
	logic is_ctrl_s1;

	bank_req_t bank_req;
	bank_rsp_t bank_rsp;

	logic [DATA_W-1:0] ctrl_rdata;
	logic [DATA_W-1:0] rdata_d;
	logic              err_d;
	logic              hit_d;
	logic [IDX_W-1:0]  idx_d;

	// The input stage moves on when the result register is empty or drained
	assign advance_s1 = valid_s1 && (!out_valid || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1       <= command;
			offset_s1        <= offset;
			write_data_s1    <= write_data;
			user_access_s1   <= user_access;
			fetch_address_s1 <= fetch_address;
		end
	end

	// Control register decode; a fetch ignores the offset and the privilege bit
	assign is_ctrl_s1 = (offset_s1 == OFS_CONTROL);

	// State changes only as the item leaves the input stage, so the next item
	// always sees them
	always_comb begin
		bank_req.wr_en  = advance_s1 && (command_s1 == CMD_WRITE) && !user_access_s1;
		bank_req.offset = offset_s1;
		bank_req.wdata  = write_data_s1;
	end

	fpb_comp_bank #(
		.NUM_COMPARATORS(NUM_COMPARATORS)
	) u_comp_bank (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (bank_req),
		.fetch_address (fetch_address_s1),
		.rsp           (bank_rsp)
	);

	// Control write needs the key bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (bank_req.wr_en && is_ctrl_s1 && write_data_s1[CTRL_KEY_BIT]) begin
			enable_q <= write_data_s1[CTRL_ENABLE_BIT];
		end
	end

	// Control read: enable, comparator count, revision
	always_comb begin
		ctrl_rdata                                    = '0;
		ctrl_rdata[CTRL_ENABLE_BIT]                   = enable_q;
		ctrl_rdata[CTRL_COUNT_SHIFT +: 4]             = 4'(NUM_COMPARATORS);
		ctrl_rdata[CTRL_REV_SHIFT +: 4]               = CTRL_REVISION;
	end

	// Result selection; remap and unknown offsets fall through as zero
	always_comb begin
		rdata_d = '0;
		err_d   = 1'b0;
		hit_d   = 1'b0;
		idx_d   = '0;
		case (command_s1)
			CMD_READ: begin
				if (user_access_s1) begin
					err_d = 1'b1;
				end else if (is_ctrl_s1) begin
					rdata_d = ctrl_rdata;
				end else begin
					rdata_d = bank_rsp.rdata;
				end
			end
			CMD_WRITE: begin
				err_d = user_access_s1;
			end
			CMD_FETCH: begin
				if (enable_q && bank_rsp.hit) begin
					hit_d = 1'b1;
					idx_d = bank_rsp.idx;
				end
			end
			default: begin
				// reserved command: all-zero result
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			read_data      <= rdata_d;
			bus_error      <= err_d;
			breakpoint_hit <= hit_d;
			hit_index      <= idx_d;
		end
	end

`ifndef SYNTHESIS
	a_err_excl_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bus_error && breakpoint_hit))
		else $error("bus error and breakpoint hit together");

	a_idx_zero_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !breakpoint_hit) |-> (hit_index == '0))
		else $error("nonzero hit index without a hit");

	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bus_error) |-> (read_data == '0))
		else $error("refused access returned data");

	a_hit_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && (command_s1 == CMD_FETCH) && !enable_q) |=> !breakpoint_hit)
		else $error("breakpoint hit while unit disabled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty stage");
`endif

endmodule
